FILE: sv/mri_pkg.sv
// Shared types and constants of the mesh router input unit.
`timescale 1ns / 1ps
`default_nettype none
package mri_pkg;

  localparam int PORTS   = 5;
  localparam int ID_W    = 2;
  localparam int HEAD_W  = 32;
  localparam int PORT_W  = 3;

  localparam logic [PORT_W-1:0] PORT_LOCAL = 3'd0;
  localparam logic [PORT_W-1:0] PORT_WEST  = 3'd1;
  localparam logic [PORT_W-1:0] PORT_EAST  = 3'd2;
  localparam logic [PORT_W-1:0] PORT_NORTH = 3'd3;
  localparam logic [PORT_W-1:0] PORT_SOUTH = 3'd4;

  typedef struct packed {
    logic push;
    logic pop;
  } mri_fifo_cmd_t;

  typedef struct packed {
    logic nonempty;
    logic full;
  } mri_fifo_sts_t;

  typedef struct packed {
    logic [HEAD_W-1:0] head_local;
    logic [HEAD_W-1:0] head_west;
    logic [HEAD_W-1:0] head_east;
    logic [HEAD_W-1:0] head_north;
    logic [HEAD_W-1:0] head_south;
    logic [PORTS-1:0]  out_valid_mask;
    logic              any_full;
  } mri_result_t;

endpackage
`default_nettype wire

FILE: sv/mri_in_if.sv
// Input channel: flit, flit valid flag and per-port read requests.
`timescale 1ns / 1ps
`default_nettype none
interface mri_in_if #(
  parameter int FLIT_WIDTH = 32
);
  import mri_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FLIT_WIDTH-1:0] flit_in;
  logic                  flit_in_valid;
  logic [PORTS-1:0]      read_mask;

  modport source (output valid, output flit_in, output flit_in_valid, output read_mask,
                  input ready);
  modport sink   (input valid, input flit_in, input flit_in_valid, input read_mask,
                  output ready);
endinterface
`default_nettype wire

FILE: sv/mri_out_if.sv
// Result channel: FIFO heads, valid mask and full flag.
`timescale 1ns / 1ps
`default_nettype none
interface mri_out_if;
  import mri_pkg::*;

  logic              valid;
  logic              ready;
  logic [HEAD_W-1:0] head_local;
  logic [HEAD_W-1:0] head_west;
  logic [HEAD_W-1:0] head_east;
  logic [HEAD_W-1:0] head_north;
  logic [HEAD_W-1:0] head_south;
  logic [PORTS-1:0]  out_valid_mask;
  logic              any_full;

  modport source (output valid, output head_local, output head_west, output head_east,
                  output head_north, output head_south, output out_valid_mask,
                  output any_full, input ready);
  modport sink   (input valid, input head_local, input head_west, input head_east,
                  input head_north, input head_south, input out_valid_mask,
                  input any_full, output ready);
endinterface
`default_nettype wire

FILE: sv/mri_cfg_if.sv
// Configuration write channel carrying the router ID.
`timescale 1ns / 1ps
`default_nettype none
interface mri_cfg_if;
  import mri_pkg::*;

  logic            valid;
  logic            ready;
  logic [ID_W-1:0] mesh_pos;

  modport source (output valid, output mesh_pos, input ready);
  modport sink   (input valid, input mesh_pos, output ready);
endinterface
`default_nettype wire

FILE: sv/mri_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mri_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: sv/mri_port_fifo.sv
// One output port FIFO: RAM storage, pointers and head prefetch with write bypass.
`timescale 1ns / 1ps
`default_nettype none
module mri_port_fifo #(
  parameter int FLIT_WIDTH = 32,
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mri_pkg::mri_fifo_cmd_t cmd,
  input  wire logic [FLIT_WIDTH-1:0] wdata,
  output mri_pkg::mri_fifo_sts_t     sts,
  output logic [FLIT_WIDTH-1:0]      head
);
  import mri_pkg::*;

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int OW = $clog2(FIFO_DEPTH + 1);
  localparam int SW = ((OW > AW) ? OW : AW) + 1;
  localparam logic [OW-1:0] DEPTH_O = OW'(FIFO_DEPTH);
  localparam logic [SW-1:0] DEPTH_S = SW'(FIFO_DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(FIFO_DEPTH - 1);

  logic [AW-1:0]         rptr_r, rptr_nxt;
  logic [OW-1:0]         occ_r, occ_nxt;
  logic [SW-1:0]         wsum;
  logic [AW-1:0]         wptr;
  logic                  do_push, do_pop;
  logic [FLIT_WIDTH-1:0] ram_q;
  logic                  byp_r, byp_nxt;
  logic [FLIT_WIDTH-1:0] byp_data_r;
  logic [FLIT_WIDTH-1:0] head_q;

  assign sts.nonempty = (occ_r != '0);
  assign sts.full     = (occ_r >= DEPTH_O);
  assign do_push      = cmd.push && !sts.full;
  assign do_pop       = cmd.pop && sts.nonempty;

  always_comb begin
    wsum = SW'(rptr_r) + SW'(occ_r);
    if (wsum >= DEPTH_S) begin
      wsum = wsum - DEPTH_S;
    end
    wptr = wsum[AW-1:0];

    rptr_nxt = rptr_r;
    if (do_pop) begin
      rptr_nxt = (rptr_r == LAST_A) ? '0 : rptr_r + 1'b1;
    end

    occ_nxt = occ_r;
    if (do_push && !do_pop) begin
      occ_nxt = occ_r + 1'b1;
    end else if (do_pop && !do_push) begin
      occ_nxt = occ_r - 1'b1;
    end

    byp_nxt = do_push && (wptr == rptr_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rptr_r <= '0;
      occ_r  <= '0;
      byp_r  <= 1'b0;
    end else begin
      rptr_r <= rptr_nxt;
      occ_r  <= occ_nxt;
      byp_r  <= byp_nxt;
    end
    byp_data_r <= wdata;
  end

  mri_ram #(
    .WIDTH(FLIT_WIDTH),
    .DEPTH(FIFO_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (do_push),
    .waddr(wptr),
    .wdata(wdata),
    .raddr(rptr_nxt),
    .rdata(ram_q)
  );

  assign head_q = byp_r ? byp_data_r : ram_q;
  assign head   = sts.nonempty ? head_q : '0;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= DEPTH_O)
    else $error("fifo occupancy above depth");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (occ_r == $past(occ_r) - 1'b1))
    else $error("pop did not reduce occupancy");

  a_push_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && (occ_r == '0)) |=> (head_q == $past(wdata)))
    else $error("flit pushed into empty fifo is not the head");
endmodule
`default_nettype wire

FILE: sv/mri_route.sv
// YX route selection with packet flit counter and held body-flit port.
`timescale 1ns / 1ps
`default_nettype none
module mri_route #(
  parameter int FLIT_WIDTH         = 32,
  parameter int SEQ_FIELD_WIDTH    = 4,
  parameter int FLITS_PER_PACKET_N = 4
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    flit_take,
  input  wire logic [FLIT_WIDTH-1:0]   flit,
  input  wire logic [mri_pkg::ID_W-1:0] mesh_pos,
  output logic [mri_pkg::PORT_W-1:0]   port
);
  import mri_pkg::*;

  localparam int DLO = FLIT_WIDTH - SEQ_FIELD_WIDTH - ID_W;
  localparam int CW  = (FLITS_PER_PACKET_N > 1) ? $clog2(FLITS_PER_PACKET_N) : 1;
  localparam logic [CW:0] LAST_C = (CW + 1)'(FLITS_PER_PACKET_N);

  logic [ID_W-1:0]   dst;
  logic [PORT_W-1:0] route_port;
  logic [PORT_W-1:0] port_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW:0]       cnt_inc;

  for (genvar k = 0; k < ID_W; k++) begin : g_dst
    if (DLO + k >= 0) begin : g_in
      assign dst[k] = flit[DLO + k];
    end else begin : g_zero
      assign dst[k] = 1'b0;
    end
  end

  always_comb begin
    if (dst == mesh_pos) begin
      route_port = PORT_LOCAL;
    end else if (dst[1] == mesh_pos[1]) begin
      route_port = (dst[0] && !mesh_pos[0]) ? PORT_WEST : PORT_EAST;
    end else begin
      route_port = (dst[1] && !mesh_pos[1]) ? PORT_NORTH : PORT_SOUTH;
    end

    port = (cnt_r == '0) ? route_port : port_r;

    cnt_inc = {1'b0, cnt_r} + 1'b1;
    cnt_nxt = (cnt_inc >= LAST_C) ? '0 : cnt_inc[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      port_r <= PORT_LOCAL;
    end else if (flit_take) begin
      cnt_r  <= cnt_nxt;
      port_r <= port;
    end
  end
endmodule
`default_nettype wire

FILE: sv/mesh_router_input_unit.sv
// Top level of the mesh router input unit: routing, five port FIFOs, result buffer.
`timescale 1ns / 1ps
`default_nettype none
// Accepts one transfer per clock and returns exactly one result per transfer, registered
// in the output buffer. Each result shows every port FIFO's head, the read-valid mask and
// the any-full flag as they stood before that transfer's push and pop. The FIFO heads
// come from one RAM per port, read ahead at the next read pointer with a write bypass. A
// two-entry output buffer keeps in_ch.ready a registered signal; input stalls only when
// both entries hold results the sink has not taken. Router ID writes are taken in any
// cycle.
module mesh_router_input_unit #(
  parameter int FLIT_WIDTH         = 32,
  parameter int SEQ_FIELD_WIDTH    = 4,
  parameter int FLITS_PER_PACKET_N = 4,
  parameter int FIFO_DEPTH         = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mri_in_if.sink    in_ch,
  mri_out_if.source out_ch,
  mri_cfg_if.sink   cfg_ch
);
  import mri_pkg::*;

  localparam int HW = (FLIT_WIDTH < HEAD_W) ? FLIT_WIDTH : HEAD_W;

  logic              in_fire, flit_take, pop_out;
  logic [ID_W-1:0]   mesh_pos_r;
  logic [PORT_W-1:0] port;
  mri_fifo_cmd_t     cmd   [PORTS];
  mri_fifo_sts_t     sts   [PORTS];
  logic [FLIT_WIDTH-1:0] heads [PORTS];
  logic [HEAD_W-1:0]     head32 [PORTS];
  logic [PORTS-1:0]  vmask, fullv;
  mri_result_t       res;
  mri_result_t       od_r, sd_r;
  logic              ov_r, sv_r;

  assign in_ch.ready  = !sv_r;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign flit_take    = in_fire && in_ch.flit_in_valid;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mesh_pos_r <= '0;
    end else if (cfg_ch.valid) begin
      mesh_pos_r <= cfg_ch.mesh_pos;
    end
  end

  mri_route #(
    .FLIT_WIDTH        (FLIT_WIDTH),
    .SEQ_FIELD_WIDTH   (SEQ_FIELD_WIDTH),
    .FLITS_PER_PACKET_N(FLITS_PER_PACKET_N)
  ) u_route (
    .clk      (clk),
    .rst_n    (rst_n),
    .flit_take(flit_take),
    .flit     (in_ch.flit_in),
    .mesh_pos (mesh_pos_r),
    .port     (port)
  );

  for (genvar p = 0; p < PORTS; p++) begin : g_port
    assign cmd[p].push = flit_take && (port == PORT_W'(p));
    assign cmd[p].pop  = in_fire && in_ch.read_mask[p];

    mri_port_fifo #(
      .FLIT_WIDTH(FLIT_WIDTH),
      .FIFO_DEPTH(FIFO_DEPTH)
    ) u_fifo (
      .clk  (clk),
      .rst_n(rst_n),
      .cmd  (cmd[p]),
      .wdata(in_ch.flit_in),
      .sts  (sts[p]),
      .head (heads[p])
    );

    assign head32[p] = HEAD_W'(heads[p][HW-1:0]);
    assign vmask[p]  = sts[p].nonempty && in_ch.read_mask[p];
    assign fullv[p]  = sts[p].full;
  end

  always_comb begin
    res.head_local     = head32[PORT_LOCAL];
    res.head_west      = head32[PORT_WEST];
    res.head_east      = head32[PORT_EAST];
    res.head_north     = head32[PORT_NORTH];
    res.head_south     = head32[PORT_SOUTH];
    res.out_valid_mask = vmask;
    res.any_full       = |fullv;
  end

  assign pop_out = ov_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (sv_r) begin
      if (pop_out) begin
        sv_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (ov_r && !out_ch.ready) begin
        sv_r <= 1'b1;
      end else begin
        ov_r <= 1'b1;
      end
    end else if (pop_out) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sv_r) begin
      if (pop_out) begin
        od_r <= sd_r;
      end
    end else if (in_fire) begin
      if (ov_r && !out_ch.ready) begin
        sd_r <= res;
      end else begin
        od_r <= res;
      end
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.head_local     = od_r.head_local;
  assign out_ch.head_west      = od_r.head_west;
  assign out_ch.head_east      = od_r.head_east;
  assign out_ch.head_north     = od_r.head_north;
  assign out_ch.head_south     = od_r.head_south;
  assign out_ch.out_valid_mask = od_r.out_valid_mask;
  assign out_ch.any_full       = od_r.any_full;

  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r |-> ov_r)
    else $error("skid entry held without main entry");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && ov_r && !out_ch.ready) |=> (sv_r && ov_r))
    else $error("transfer during output stall not buffered");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!ov_r && !sv_r))
    else $error("output buffer not empty after reset");
endmodule
`default_nettype wire
